### rtl/core/bcc_pkg.sv
package bcc_pkg;

  localparam int unsigned TIME_W     = 32;
  localparam int unsigned DEBOUNCE_W = 10;
  localparam int unsigned LONG_W     = 16;
  localparam int unsigned GAP_W      = 16;
  localparam int unsigned ELAPSED_W  = 10;
  localparam int unsigned EVENT_W    = 2;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 16;

  localparam logic [DEBOUNCE_W-1:0] DEBOUNCE_RST = DEBOUNCE_W'(30);
  localparam logic [LONG_W-1:0]     LONG_RST     = LONG_W'(2000);
  localparam logic [GAP_W-1:0]      GAP_RST      = GAP_W'(300);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_DEBOUNCE = 2'd0,
    CFG_LONG     = 2'd1,
    CFG_GAP      = 2'd2
  } cfg_idx_e;

  typedef enum logic [EVENT_W-1:0] {
    EVT_NONE   = 2'd0,
    EVT_SHORT  = 2'd1,
    EVT_DOUBLE = 2'd2,
    EVT_LONG   = 2'd3
  } evt_e;

endpackage

### rtl/core/bcc_in_if.sv
interface bcc_in_if;
  logic                           valid;
  logic                           ready;
  logic                           btn_raw;
  logic [bcc_pkg::ELAPSED_W-1:0]  elapsed_ms;

  modport source (output valid, output btn_raw, output elapsed_ms, input ready);
  modport sink (input valid, input btn_raw, input elapsed_ms, output ready);
endinterface

### rtl/core/bcc_out_if.sv
interface bcc_out_if;
  logic                          valid;
  logic                          ready;
  logic [bcc_pkg::EVENT_W-1:0]   event_code;
  logic                          debounced_level;

  modport source (output valid, output event_code, output debounced_level, input ready);
  modport sink (input valid, input event_code, input debounced_level, output ready);
endinterface

### rtl/core/button_click_classifier_top.sv
// Push button classifier: each input beat is one poll sample (raw level and the
// milliseconds since the previous sample), and each sample yields exactly one
// output beat with the event code (none, short, double or long press) and the
// debounced level. Samples can be taken one per clock cycle while results are
// taken. A sample waits in the input register until it advances; the single
// classification stage then updates the running time and press state and loads
// the result register, which offers the result at the output. While a result
// waits, one more sample can be taken into the input register; the input then
// stalls until the waiting result beat is taken. The user must write thresholds
// through the configuration port while no sample is in flight (not enforced).
module button_click_classifier_top (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  bcc_in_if.sink                          in_i,
  bcc_out_if.source                       out_o,
  input  logic                            cfg_we_i,
  input  logic [bcc_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [bcc_pkg::CFG_DATA_W-1:0]  cfg_wdata_i
);

  localparam int unsigned TW = bcc_pkg::TIME_W;

  // Configuration registers.
  logic [bcc_pkg::DEBOUNCE_W-1:0] debounce_q;
  logic [bcc_pkg::LONG_W-1:0]     long_q;
  logic [bcc_pkg::GAP_W-1:0]      gap_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      debounce_q <= bcc_pkg::DEBOUNCE_RST;
      long_q     <= bcc_pkg::LONG_RST;
      gap_q      <= bcc_pkg::GAP_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        bcc_pkg::CFG_DEBOUNCE: debounce_q <= cfg_wdata_i[bcc_pkg::DEBOUNCE_W-1:0];
        bcc_pkg::CFG_LONG:     long_q     <= cfg_wdata_i[bcc_pkg::LONG_W-1:0];
        bcc_pkg::CFG_GAP:      gap_q      <= cfg_wdata_i[bcc_pkg::GAP_W-1:0];
        default: ;
      endcase
    end
  end

  // Input register stage.
  logic                          in_valid_q;
  logic                          raw_q;
  logic [bcc_pkg::ELAPSED_W-1:0] elapsed_q;
  logic                          advance;

  assign advance    = in_valid_q && (!out_o.valid || out_o.ready);
  assign in_i.ready = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      in_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      raw_q     <= in_i.btn_raw;
      elapsed_q <= in_i.elapsed_ms;
    end
  end

  // Classifier state.
  logic [TW-1:0] time_now_q, time_now_d;
  logic          stable_q, stable_d;
  logic          prev_raw_q;
  logic [TW-1:0] last_change_q, last_change_d;
  logic [TW-1:0] press_start_q, press_start_d;
  logic          long_rep_q, long_rep_d;
  logic          pend_q, pend_d;
  logic [TW-1:0] pend_since_q, pend_since_d;
  bcc_pkg::evt_e evt;

  logic          raw_changed;
  logic [TW-1:0] since_change;
  logic [TW-1:0] held;
  logic [TW-1:0] held_after;
  logic [TW-1:0] pend_age;
  logic          commit;
  logic          press_edge;
  logic          release_edge;

  always_comb begin
    time_now_d  = time_now_q + TW'(elapsed_q);
    raw_changed = (raw_q != prev_raw_q);
    // A fresh raw edge restarts the stability window at the current time.
    since_change  = raw_changed ? '0 : (time_now_d - last_change_q);
    last_change_d = raw_changed ? time_now_d : last_change_q;
    held          = time_now_d - press_start_q;
    pend_age      = time_now_d - pend_since_q;

    commit       = (raw_q != stable_q) && (since_change >= TW'(debounce_q));
    press_edge   = commit && raw_q;
    release_edge = commit && !raw_q;

    stable_d      = commit ? raw_q : stable_q;
    press_start_d = press_edge ? time_now_d : press_start_q;
    long_rep_d    = press_edge ? 1'b0 : long_rep_q;
    held_after    = press_edge ? '0 : held;
    pend_d        = pend_q;
    pend_since_d  = pend_since_q;
    evt           = bcc_pkg::EVT_NONE;

    if (release_edge && (held < TW'(long_q))) begin
      if (pend_q && (pend_age <= TW'(gap_q))) begin
        pend_d = 1'b0;
        evt    = bcc_pkg::EVT_DOUBLE;
      end else begin
        pend_d       = 1'b1;
        pend_since_d = time_now_d;
      end
    end

    if (stable_d && !long_rep_d && (held_after >= TW'(long_q))) begin
      long_rep_d = 1'b1;
      pend_d     = 1'b0;
      evt        = bcc_pkg::EVT_LONG;
    end

    // A click registered in this sample has age zero and cannot expire here.
    if (pend_d && ((time_now_d - pend_since_d) > TW'(gap_q))) begin
      pend_d = 1'b0;
      evt    = bcc_pkg::EVT_SHORT;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      time_now_q    <= '0;
      stable_q      <= 1'b0;
      prev_raw_q    <= 1'b0;
      last_change_q <= '0;
      press_start_q <= '0;
      long_rep_q    <= 1'b0;
      pend_q        <= 1'b0;
      pend_since_q  <= '0;
    end else if (advance) begin
      time_now_q    <= time_now_d;
      stable_q      <= stable_d;
      prev_raw_q    <= raw_q;
      last_change_q <= last_change_d;
      press_start_q <= press_start_d;
      long_rep_q    <= long_rep_d;
      pend_q        <= pend_d;
      pend_since_q  <= pend_since_d;
    end
  end

  // Result register.
  logic                        out_valid_q;
  logic [bcc_pkg::EVENT_W-1:0] event_q;
  logic                        level_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (!out_valid_q || out_o.ready) begin
      out_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      event_q <= evt;
      level_q <= stable_d;
    end
  end

  assign out_o.valid           = out_valid_q;
  assign out_o.event_code      = event_q;
  assign out_o.debounced_level = level_q;

`ifndef SYNTHESIS
  a_long_while_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && (event_q == bcc_pkg::EVT_LONG) |-> level_q)
    else $error("long press reported while released");

  a_double_on_release: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && (event_q == bcc_pkg::EVT_DOUBLE) |-> !level_q)
    else $error("double press reported while held");

  a_no_pending_after_long: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && (evt == bcc_pkg::EVT_LONG) |=> !pend_q)
    else $error("click left pending after long press");

  a_stalled_input_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_q && !advance |=> in_valid_q && $stable(raw_q) && $stable(elapsed_q))
    else $error("input stage lost a stalled sample");
`endif

endmodule

### tb/sv/button_click_classifier_top_tb.sv
module button_click_classifier_top_tb;

  localparam int unsigned CYCLE_LIMIT     = 1_000_000;
  localparam int unsigned ITEMS_PER_PHASE = 180;
  localparam int unsigned N_PHASES        = 8;
  localparam int unsigned N_DIRECTED      = 29;
  localparam int unsigned MAX_PRINTED     = 200;

  typedef struct {
    bcc_pkg::evt_e evt;
    logic          lvl;
  } click_result_t;

  typedef struct {
    bit            raw;
    int            el;
    bit            typed;
    bcc_pkg::evt_e evt;
    bit            lvl;
  } sample_row_t;

  logic clk;
  logic rst_n;
  logic                           cfg_we;
  bcc_pkg::cfg_idx_e              cfg_idx;
  logic [bcc_pkg::CFG_DATA_W-1:0] cfg_wdata;

  bcc_in_if  in_if ();
  bcc_out_if out_if ();

  button_click_classifier_top u_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_i        (in_if),
    .out_o       (out_if),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata)
  );

  // Thresholds and press state as the classifier should hold them.
  logic [bcc_pkg::DEBOUNCE_W-1:0] thr_debounce;
  logic [bcc_pkg::LONG_W-1:0]     thr_long;
  logic [bcc_pkg::GAP_W-1:0]      thr_gap;
  logic [bcc_pkg::TIME_W-1:0]     now_ms;
  logic                           stable_lvl;
  logic                           prev_btn;
  logic [bcc_pkg::TIME_W-1:0]     change_ms;
  logic [bcc_pkg::TIME_W-1:0]     press_ms;
  logic                           long_done;
  logic                           click_wait;
  logic [bcc_pkg::TIME_W-1:0]     click_ms;

  click_result_t pending_results[$];
  int unsigned   mismatches;
  int unsigned   results_seen;
  int unsigned   cycles;

  // Rows with a typed result are easy to read off by hand; the rest go through
  // classify_sample. Thresholds are the reset values here.
  sample_row_t dir_rows [N_DIRECTED] = '{
    '{1'b0,    0, 1'b1, bcc_pkg::EVT_NONE,   1'b0},
    '{1'b1,   10, 1'b1, bcc_pkg::EVT_NONE,   1'b0},
    '{1'b1,   30, 1'b1, bcc_pkg::EVT_NONE,   1'b1},
    '{1'b0,  100, 1'b0, bcc_pkg::EVT_NONE,   1'b0},
    '{1'b0,   30, 1'b0, bcc_pkg::EVT_NONE,   1'b0},
    '{1'b1,   50, 1'b0, bcc_pkg::EVT_NONE,   1'b0},
    '{1'b1,   30, 1'b0, bcc_pkg::EVT_NONE,   1'b0},
    '{1'b0,   40, 1'b0, bcc_pkg::EVT_NONE,   1'b0},
    '{1'b0,   30, 1'b1, bcc_pkg::EVT_DOUBLE, 1'b0},
    '{1'b1,   30, 1'b0, bcc_pkg::EVT_NONE,   1'b0},
    '{1'b1,   30, 1'b0, bcc_pkg::EVT_NONE,   1'b0},
    '{1'b0,   30, 1'b0, bcc_pkg::EVT_NONE,   1'b0},
    '{1'b0,   30, 1'b0, bcc_pkg::EVT_NONE,   1'b0},
    '{1'b0, 1023, 1'b1, bcc_pkg::EVT_SHORT,  1'b0},
    '{1'b1, 1023, 1'b0, bcc_pkg::EVT_NONE,   1'b0},
    '{1'b1,   30, 1'b0, bcc_pkg::EVT_NONE,   1'b0},
    '{1'b1, 1023, 1'b0, bcc_pkg::EVT_NONE,   1'b0},
    '{1'b1, 1023, 1'b1, bcc_pkg::EVT_LONG,   1'b1},
    '{1'b0,   30, 1'b0, bcc_pkg::EVT_NONE,   1'b0},
    '{1'b0,   30, 1'b1, bcc_pkg::EVT_NONE,   1'b0},
    // A click goes pending, then a second release lands only after a big
    // time step, so the stale click is replaced without a short press.
    '{1'b1,   30, 1'b0, bcc_pkg::EVT_NONE,   1'b0},
    '{1'b1,   30, 1'b0, bcc_pkg::EVT_NONE,   1'b0},
    '{1'b0,   10, 1'b0, bcc_pkg::EVT_NONE,   1'b0},
    '{1'b0,   30, 1'b0, bcc_pkg::EVT_NONE,   1'b0},
    '{1'b1,   30, 1'b0, bcc_pkg::EVT_NONE,   1'b0},
    '{1'b1,   30, 1'b0, bcc_pkg::EVT_NONE,   1'b0},
    '{1'b0,   10, 1'b0, bcc_pkg::EVT_NONE,   1'b0},
    '{1'b0, 1023, 1'b0, bcc_pkg::EVT_NONE,   1'b0},
    '{1'b0,  400, 1'b0, bcc_pkg::EVT_NONE,   1'b0}
  };

  always #10 clk = ~clk;

  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  task automatic report_mismatch(input string msg);
    if (mismatches < MAX_PRINTED) begin
      $display("MISMATCH result %0d: %s", results_seen, msg);
    end
    mismatches++;
  endtask

  function automatic click_result_t classify_sample(
      input logic raw, input logic [bcc_pkg::ELAPSED_W-1:0] el);
    click_result_t              res;
    logic [bcc_pkg::TIME_W-1:0] held;
    res.evt = bcc_pkg::EVT_NONE;
    now_ms = now_ms + bcc_pkg::TIME_W'(el);
    if (raw != prev_btn) begin
      prev_btn  = raw;
      change_ms = now_ms;
    end
    if (raw != stable_lvl &&
        (now_ms - change_ms) >= bcc_pkg::TIME_W'(thr_debounce)) begin
      stable_lvl = raw;
      if (stable_lvl) begin
        press_ms  = now_ms;
        long_done = 1'b0;
      end else begin
        held = now_ms - press_ms;
        // A release after a long hold stays silent.
        if (held < bcc_pkg::TIME_W'(thr_long)) begin
          if (click_wait && (now_ms - click_ms) <= bcc_pkg::TIME_W'(thr_gap)) begin
            click_wait = 1'b0;
            res.evt    = bcc_pkg::EVT_DOUBLE;
          end else begin
            click_wait = 1'b1;
            click_ms   = now_ms;
          end
        end
      end
    end
    if (stable_lvl && !long_done &&
        (now_ms - press_ms) >= bcc_pkg::TIME_W'(thr_long)) begin
      long_done  = 1'b1;
      click_wait = 1'b0;
      res.evt    = bcc_pkg::EVT_LONG;
    end
    if (click_wait && (now_ms - click_ms) > bcc_pkg::TIME_W'(thr_gap)) begin
      click_wait = 1'b0;
      res.evt    = bcc_pkg::EVT_SHORT;
    end
    res.lvl = stable_lvl;
    return res;
  endfunction

  task automatic write_reg(input bcc_pkg::cfg_idx_e idx,
                           input logic [bcc_pkg::CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= val;
    case (idx)
      bcc_pkg::CFG_DEBOUNCE: thr_debounce = val[bcc_pkg::DEBOUNCE_W-1:0];
      bcc_pkg::CFG_LONG:     thr_long     = val[bcc_pkg::LONG_W-1:0];
      bcc_pkg::CFG_GAP:      thr_gap      = val[bcc_pkg::GAP_W-1:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic idle_cycles(input int unsigned n);
    repeat (n) begin
      @(negedge clk);
      in_if.valid      <= 1'b0;
      in_if.btn_raw    <= 1'($urandom);
      in_if.elapsed_ms <= bcc_pkg::ELAPSED_W'($urandom);
    end
  endtask

  task automatic wait_results_drained();
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic send_sample(input logic raw, input logic [bcc_pkg::ELAPSED_W-1:0] el,
                             output click_result_t predicted);
    @(negedge clk);
    in_if.valid      <= 1'b1;
    in_if.btn_raw    <= raw;
    in_if.elapsed_ms <= el;
    do @(posedge clk); while (!in_if.ready);
    predicted = classify_sample(raw, el);
  endtask

  function automatic int unsigned sender_gap(input bit busy);
    int unsigned sel;
    sel = $urandom_range(0, 99);
    if (!busy || sel < 60) return 0;
    if (sel < 90) return $urandom_range(1, 3);
    if (sel < 98) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [bcc_pkg::ELAPSED_W-1:0] pick_elapsed();
    int unsigned sel;
    sel = $urandom_range(0, 19);
    if (sel < 8)   return bcc_pkg::ELAPSED_W'($urandom_range(0, 15));
    if (sel < 14)  return bcc_pkg::ELAPSED_W'($urandom_range(0, 100));
    if (sel < 18)  return bcc_pkg::ELAPSED_W'($urandom_range(0, 400));
    if (sel == 18) return '1;
    return bcc_pkg::ELAPSED_W'($urandom);
  endfunction

  // Result side: ready toggles in bursts, with the odd long stall or long
  // stretch of steady ready.
  initial begin
    int unsigned run;
    int unsigned stall;
    int unsigned sel;
    out_if.ready = 1'b0;
    forever begin
      run = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300) : $urandom_range(1, 20);
      repeat (run) @(negedge clk) out_if.ready <= 1'b1;
      sel = $urandom_range(0, 99);
      if (sel < 40)      stall = 0;
      else if (sel < 80) stall = $urandom_range(1, 3);
      else if (sel < 95) stall = $urandom_range(4, 12);
      else               stall = $urandom_range(30, 80);
      repeat (stall) @(negedge clk) out_if.ready <= 1'b0;
    end
  end

  always @(posedge clk) begin
    click_result_t exp_r;
    if (rst_n && out_if.valid && out_if.ready) begin
      if (pending_results.size() == 0) begin
        report_mismatch("result beat with no sample waiting for it");
      end else begin
        exp_r = pending_results.pop_front();
        if (out_if.event_code !== exp_r.evt) begin
          report_mismatch($sformatf("event_code %0d, expected %0d",
                                    out_if.event_code, exp_r.evt));
        end
        if (out_if.debounced_level !== exp_r.lvl) begin
          report_mismatch($sformatf("debounced_level %0b, expected %0b",
                                    out_if.debounced_level, exp_r.lvl));
        end
      end
      results_seen++;
    end
  end

  initial begin
    click_result_t predicted;
    logic          cur;
    logic          raw;
    int unsigned   run;
    int unsigned   sent;
    bit            busy;

    clk              = 1'b0;
    rst_n            = 1'b0;
    cfg_we           = 1'b0;
    cfg_idx          = bcc_pkg::CFG_DEBOUNCE;
    cfg_wdata        = '0;
    in_if.valid      = 1'b0;
    in_if.btn_raw    = 1'b0;
    in_if.elapsed_ms = '0;
    mismatches       = 0;
    results_seen     = 0;
    cycles           = 0;

    thr_debounce = bcc_pkg::DEBOUNCE_RST;
    thr_long     = bcc_pkg::LONG_RST;
    thr_gap      = bcc_pkg::GAP_RST;
    now_ms       = '0;
    stable_lvl   = 1'b0;
    prev_btn     = 1'b0;
    change_ms    = '0;
    press_ms     = '0;
    long_done    = 1'b0;
    click_wait   = 1'b0;
    click_ms     = '0;

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (dir_rows[i]) begin
      send_sample(dir_rows[i].raw, bcc_pkg::ELAPSED_W'(dir_rows[i].el), predicted);
      if (dir_rows[i].typed) begin
        predicted.evt = dir_rows[i].evt;
        predicted.lvl = dir_rows[i].lvl;
      end
      pending_results.push_back(predicted);
      idle_cycles(sender_gap(1'b1));
    end

    cur = stable_lvl;
    for (int p = 0; p < N_PHASES; p++) begin
      if (p > 0) begin
        idle_cycles(1);
        wait_results_drained();
        repeat (4) @(posedge clk);
        case (p)
          1: begin
            write_reg(bcc_pkg::CFG_DEBOUNCE, '0);
            write_reg(bcc_pkg::CFG_LONG, '0);
            write_reg(bcc_pkg::CFG_GAP, '0);
          end
          2: begin
            write_reg(bcc_pkg::CFG_DEBOUNCE, bcc_pkg::CFG_DATA_W'(10'h3FF));
            write_reg(bcc_pkg::CFG_LONG, '1);
            write_reg(bcc_pkg::CFG_GAP, '1);
          end
          3: begin
            write_reg(bcc_pkg::CFG_DEBOUNCE, bcc_pkg::CFG_DATA_W'(10));
            write_reg(bcc_pkg::CFG_LONG, bcc_pkg::CFG_DATA_W'(150));
            write_reg(bcc_pkg::CFG_GAP, bcc_pkg::CFG_DATA_W'(120));
          end
          default: begin
            write_reg(bcc_pkg::CFG_DEBOUNCE, bcc_pkg::CFG_DATA_W'($urandom_range(0, 60)));
            write_reg(bcc_pkg::CFG_LONG, bcc_pkg::CFG_DATA_W'($urandom_range(0, 3000)));
            write_reg(bcc_pkg::CFG_GAP, bcc_pkg::CFG_DATA_W'($urandom_range(0, 800)));
          end
        endcase
      end
      // Every third phase streams samples back to back.
      busy = (p % 3) != 1;
      sent = 0;
      while (sent < ITEMS_PER_PHASE) begin
        cur = ~cur;
        run = ($urandom_range(0, 4) == 0) ? 1 : $urandom_range(2, 16);
        for (int k = 0; k < run && sent < ITEMS_PER_PHASE; k++) begin
          // Occasional bounce against the intended level.
          raw = ($urandom_range(0, 9) == 0) ? ~cur : cur;
          send_sample(raw, pick_elapsed(), predicted);
          pending_results.push_back(predicted);
          sent++;
          if ($urandom_range(0, 149) == 0) begin
            idle_cycles(1);
            wait_results_drained();
          end else begin
            idle_cycles(sender_gap(busy));
          end
        end
      end
    end

    idle_cycles(1);
    wait_results_drained();
    repeat (10) @(posedge clk);
    if (mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

### sim.f
rtl/core/bcc_pkg.sv
rtl/core/bcc_in_if.sv
rtl/core/bcc_out_if.sv
rtl/core/button_click_classifier_top.sv
tb/sv/button_click_classifier_top_tb.sv
